// File: rtl/tcpq_pkg.sv
// ----------------------------------------------------------------------------
// tcpq_pkg
// Shared types, sizes and codes of the three class priority queue.
// ----------------------------------------------------------------------------
package tcpq_pkg;

  localparam int CLASS_DEPTH = 32;
  localparam int NUM_CLASSES = 3;

  localparam int VALUE_W   = 3;
  localparam int STATUS_W  = 2;
  localparam int CLS_W     = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 3;

  localparam int PTR_W  = $clog2(CLASS_DEPTH);
  localparam int CNT_W  = $clog2(CLASS_DEPTH + 1);
  localparam int ADDR_W = $clog2(NUM_CLASSES * CLASS_DEPTH);

  localparam logic [VALUE_W-1:0] VALUE_MIN = VALUE_W'(1);
  localparam logic [VALUE_W-1:0] VALUE_MAX = VALUE_W'(5);

  localparam logic [VALUE_W-1:0] CLASS_ZERO_MAX_RST = VALUE_W'(1);
  localparam logic [VALUE_W-1:0] CLASS_ONE_MAX_RST  = VALUE_W'(3);

  typedef enum logic {
    OP_ENQUEUE = 1'b0,
    OP_DEQUEUE = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK      = 2'd0,
    STATUS_EMPTY   = 2'd1,
    STATUS_FULL    = 2'd2,
    STATUS_INVALID = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CLASS_ZERO_MAX = 2'd0,
    CFG_CLASS_ONE_MAX  = 2'd1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    CTRL_IDLE,
    CTRL_EXEC,
    CTRL_LOAD
  } ctrl_state_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load_item;
    logic exec;
    logic load_out;
  } tcpq_cmd_t;

endpackage

// File: rtl/tcpq_item_if.sv
// ----------------------------------------------------------------------------
// tcpq_item_if
// Operation channel: enqueue or dequeue request with its value.
// ----------------------------------------------------------------------------
interface tcpq_item_if;
  logic                         valid;
  logic                         ready;
  logic                         operation;
  logic [tcpq_pkg::VALUE_W-1:0] item_value;

  modport source (output valid, output operation, output item_value, input ready);
  modport sink   (input valid, input operation, input item_value, output ready);
endinterface

// File: rtl/tcpq_result_if.sv
// ----------------------------------------------------------------------------
// tcpq_result_if
// Result channel: one result per operation.
// ----------------------------------------------------------------------------
interface tcpq_result_if;
  logic                          valid;
  logic                          ready;
  logic [tcpq_pkg::STATUS_W-1:0] status;
  logic [tcpq_pkg::VALUE_W-1:0]  out_value;
  logic [tcpq_pkg::CLS_W-1:0]    out_class;
  logic                          is_empty;

  modport source (output valid, output status, output out_value, output out_class,
                  output is_empty, input ready);
  modport sink   (input valid, input status, input out_value, input out_class,
                  input is_empty, output ready);
endinterface

// File: rtl/tcpq_cfg_if.sv
// ----------------------------------------------------------------------------
// tcpq_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface tcpq_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [tcpq_pkg::CFG_IDX_W-1:0] index;
  logic [tcpq_pkg::CFG_DAT_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/tcpq_ctrl.sv
// ----------------------------------------------------------------------------
// tcpq_ctrl
// Controller state machine: sequences accept, execute and result load, and
// owns the handshake of both channels.
// ----------------------------------------------------------------------------
module tcpq_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output tcpq_pkg::tcpq_cmd_t cmd
);
  import tcpq_pkg::*;

  ctrl_state_t state, state_next;
  logic        out_free;

  // output register can take a new result when empty or being drained
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      CTRL_IDLE: if (in_valid) state_next = CTRL_EXEC;
      CTRL_EXEC: state_next = CTRL_LOAD;
      CTRL_LOAD: if (out_free) state_next = CTRL_IDLE;
      default:   state_next = CTRL_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = (state == CTRL_IDLE);
    cmd.load_item = (state == CTRL_IDLE) && in_valid;
    cmd.exec      = (state == CTRL_EXEC);
    cmd.load_out  = (state == CTRL_LOAD) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= CTRL_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/tcpq_datapath.sv
// ----------------------------------------------------------------------------
// tcpq_datapath
// Class rings in one storage array, per class head, tail and count,
// threshold registers and the result register.
// ----------------------------------------------------------------------------
module tcpq_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  tcpq_pkg::tcpq_cmd_t           cmd,
  input  logic                          in_operation,
  input  logic [tcpq_pkg::VALUE_W-1:0]  in_item_value,
  input  logic                          cfg_we,
  input  logic [tcpq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tcpq_pkg::CFG_DAT_W-1:0] cfg_data,
  output logic [tcpq_pkg::STATUS_W-1:0] status,
  output logic [tcpq_pkg::VALUE_W-1:0]  out_value,
  output logic [tcpq_pkg::CLS_W-1:0]    out_class,
  output logic                          is_empty
);
  import tcpq_pkg::*;

  logic [VALUE_W-1:0] class_zero_max;
  logic [VALUE_W-1:0] class_one_max;

  logic [VALUE_W-1:0] storage [NUM_CLASSES*CLASS_DEPTH];
  logic [VALUE_W-1:0] rd_data;

  logic [PTR_W-1:0] head  [NUM_CLASSES];
  logic [PTR_W-1:0] tail  [NUM_CLASSES];
  logic [CNT_W-1:0] count [NUM_CLASSES];
  logic [PTR_W-1:0] head_next  [NUM_CLASSES];
  logic [PTR_W-1:0] tail_next  [NUM_CLASSES];
  logic [CNT_W-1:0] count_next [NUM_CLASSES];

  // latched operation
  op_t                item_op;
  logic [VALUE_W-1:0] item_val;

  // result of the execute step, waiting for the storage read
  status_t          res_status, res_status_next;
  logic [CLS_W-1:0] res_class, res_class_next;
  logic             res_take, res_take_next;
  logic             res_empty, res_empty_next;

  logic [CLS_W-1:0]  enq_class;
  logic [CLS_W-1:0]  deq_class;
  logic              deq_found;
  logic              val_ok;
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] waddr, raddr;

  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(CLASS_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  function automatic logic [ADDR_W-1:0] ring_addr(input logic [CLS_W-1:0] c,
                                                  input logic [PTR_W-1:0] p);
    return ADDR_W'(c) * ADDR_W'(CLASS_DEPTH) + ADDR_W'(p);
  endfunction

  assign val_ok = (item_val >= VALUE_MIN) && (item_val <= VALUE_MAX);

  // class selection by threshold, clamped to the last class
  always_comb begin
    if (item_val <= class_zero_max) begin
      enq_class = CLS_W'(0);
    end else if (item_val <= class_one_max) begin
      enq_class = CLS_W'(1);
    end else begin
      enq_class = CLS_W'(2);
    end
    if (enq_class > CLS_W'(NUM_CLASSES - 1)) begin
      enq_class = CLS_W'(NUM_CLASSES - 1);
    end
  end

  // lowest numbered class that holds an item
  always_comb begin
    deq_found = 1'b0;
    deq_class = '0;
    for (int k = NUM_CLASSES - 1; k >= 0; k--) begin
      if (count[k] != '0) begin
        deq_found = 1'b1;
        deq_class = CLS_W'(k);
      end
    end
  end

  always_comb begin
    res_status_next = STATUS_OK;
    res_class_next  = '0;
    res_take_next   = 1'b0;
    mem_we          = 1'b0;
    mem_re          = 1'b0;
    waddr           = ring_addr(enq_class, tail[enq_class]);
    raddr           = ring_addr(deq_class, head[deq_class]);
    for (int k = 0; k < NUM_CLASSES; k++) begin
      head_next[k]  = head[k];
      tail_next[k]  = tail[k];
      count_next[k] = count[k];
    end
    if (item_op == OP_ENQUEUE) begin
      if (!val_ok) begin
        res_status_next = STATUS_INVALID;
      end else begin
        res_class_next = enq_class;
        if (count[enq_class] == CNT_W'(CLASS_DEPTH)) begin
          res_status_next = STATUS_FULL;
        end else begin
          mem_we                = cmd.exec;
          tail_next[enq_class]  = next_slot(tail[enq_class]);
          count_next[enq_class] = count[enq_class] + CNT_W'(1);
        end
      end
    end else begin
      if (!deq_found) begin
        res_status_next = STATUS_EMPTY;
      end else begin
        res_class_next        = deq_class;
        res_take_next         = 1'b1;
        mem_re                = cmd.exec;
        head_next[deq_class]  = next_slot(head[deq_class]);
        count_next[deq_class] = count[deq_class] - CNT_W'(1);
      end
    end
    res_empty_next = 1'b1;
    for (int k = 0; k < NUM_CLASSES; k++) begin
      if (count_next[k] != '0) res_empty_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) storage[waddr] <= item_val;
    if (mem_re) rd_data <= storage[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      class_zero_max <= CLASS_ZERO_MAX_RST;
      class_one_max  <= CLASS_ONE_MAX_RST;
      for (int k = 0; k < NUM_CLASSES; k++) begin
        head[k]  <= '0;
        tail[k]  <= '0;
        count[k] <= '0;
      end
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_CLASS_ZERO_MAX) class_zero_max <= cfg_data;
        if (cfg_index == CFG_CLASS_ONE_MAX)  class_one_max  <= cfg_data;
      end
      if (cmd.exec) begin
        for (int k = 0; k < NUM_CLASSES; k++) begin
          head[k]  <= head_next[k];
          tail[k]  <= tail_next[k];
          count[k] <= count_next[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_op  <= op_t'(in_operation);
      item_val <= in_item_value;
    end
    if (cmd.exec) begin
      res_status <= res_status_next;
      res_class  <= res_class_next;
      res_take   <= res_take_next;
      res_empty  <= res_empty_next;
    end
    if (cmd.load_out) begin
      status    <= res_status;
      out_value <= res_take ? rd_data : '0;
      out_class <= res_class;
      is_empty  <= res_empty;
    end
  end

endmodule

// File: rtl/three_class_priority_queue_core.sv
// ----------------------------------------------------------------------------
// three_class_priority_queue_core
// Three class priority queue, first in first out within each class.
// ----------------------------------------------------------------------------
// Each operation runs through accept, execute (class pick, head or tail and
// count update, storage write or read) and result load, which waits until the
// result register is free. The dequeued value comes out of the registered read
// port of the class storage in the cycle after the address is known. A new
// operation is accepted in the cycle after the previous result was loaded,
// even while that result still waits on the result channel, so operations do
// not overlap. Every operation gives exactly one result. Threshold registers
// are written through the configuration channel, which is always ready.
module three_class_priority_queue_core (
  input  logic          clk,
  input  logic          rst,
  tcpq_item_if.sink     item_in,
  tcpq_result_if.source result_out,
  tcpq_cfg_if.sink      cfg
);
  import tcpq_pkg::*;

  tcpq_cmd_t cmd;

  assign cfg.ready = 1'b1;

  tcpq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item_in.valid),
    .in_ready  (item_in.ready),
    .out_valid (result_out.valid),
    .out_ready (result_out.ready),
    .cmd       (cmd)
  );

  tcpq_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .in_operation  (item_in.operation),
    .in_item_value (item_in.item_value),
    .cfg_we        (cfg.valid),
    .cfg_index     (cfg.index),
    .cfg_data      (cfg.data),
    .status        (result_out.status),
    .out_value     (result_out.out_value),
    .out_class     (result_out.out_class),
    .is_empty      (result_out.is_empty)
  );

endmodule
